[hw/rtl/oal_pkg.sv]
`timescale 1ns / 1ps

package oal_pkg;

  localparam int ACTION_W   = 2;
  localparam int POSITION_W = 8;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 7;
  localparam int CAP_W      = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_GET    = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_CLEAR  = 2'd3
  } act_t;

  typedef enum logic [STATUS_W-1:0] {
    RES_OK    = 2'd0,
    RES_FULL  = 2'd1,
    RES_RANGE = 2'd2
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_UP,
    ST_INS_WR,
    ST_CAPTURE,
    ST_DOWN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic take;
    logic clear_count;
    logic set_full;
    logic set_range;
    logic rd_start_up;
    logic rd_start_pos;
    logic up_move;
    logic up_read;
    logic ins_write;
    logic capture;
    logic down_move;
    logic next_read;
    logic dec_count;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    act_t act;
    logic full;
    logic range_err;
    logic shift_needed;
    logic more_up;
    logic more_down;
    logic out_free;
  } sts_t;

endpackage

[hw/rtl/oal_ram.sv]
`timescale 1ns / 1ps

module oal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/oal_ctrl.sv]
`timescale 1ns / 1ps

module oal_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output oal_pkg::cmd_t cmd,
  input  oal_pkg::sts_t sts
);

  oal_pkg::state_t state;
  oal_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= oal_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      oal_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = oal_pkg::ST_DECODE;
        end
      end
      oal_pkg::ST_DECODE: begin
        case (sts.act)
          oal_pkg::ACT_INSERT: begin
            if (sts.full) begin
              cmd.set_full = 1'b1;
              state_next   = oal_pkg::ST_DONE;
            end else if (sts.shift_needed) begin
              cmd.rd_start_up = 1'b1;
              state_next      = oal_pkg::ST_UP;
            end else begin
              state_next = oal_pkg::ST_INS_WR;
            end
          end
          oal_pkg::ACT_GET, oal_pkg::ACT_DELETE: begin
            if (sts.range_err) begin
              cmd.set_range = 1'b1;
              state_next    = oal_pkg::ST_DONE;
            end else begin
              cmd.rd_start_pos = 1'b1;
              state_next       = oal_pkg::ST_CAPTURE;
            end
          end
          default: begin
            cmd.clear_count = 1'b1;
            state_next      = oal_pkg::ST_DONE;
          end
        endcase
      end
      oal_pkg::ST_UP: begin
        cmd.up_move = 1'b1;
        if (sts.more_up) begin
          cmd.up_read = 1'b1;
        end else begin
          state_next = oal_pkg::ST_INS_WR;
        end
      end
      oal_pkg::ST_INS_WR: begin
        cmd.ins_write = 1'b1;
        state_next    = oal_pkg::ST_DONE;
      end
      oal_pkg::ST_CAPTURE: begin
        cmd.capture = 1'b1;
        if (sts.act == oal_pkg::ACT_GET) begin
          state_next = oal_pkg::ST_DONE;
        end else if (sts.more_down) begin
          cmd.next_read = 1'b1;
          state_next    = oal_pkg::ST_DOWN;
        end else begin
          cmd.dec_count = 1'b1;
          state_next    = oal_pkg::ST_DONE;
        end
      end
      oal_pkg::ST_DOWN: begin
        cmd.down_move = 1'b1;
        if (sts.more_down) begin
          cmd.next_read = 1'b1;
        end else begin
          cmd.dec_count = 1'b1;
          state_next    = oal_pkg::ST_DONE;
        end
      end
      oal_pkg::ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = oal_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = oal_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/oal_datapath.sv]
`timescale 1ns / 1ps

module oal_datapath #(
  parameter int DEPTH       = 64,
  parameter int ENTRY_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  oal_pkg::cmd_t                     cmd,
  output oal_pkg::sts_t                     sts,
  input  logic                              cfg_write,
  input  logic [oal_pkg::CAP_W-1:0]         cfg_data,
  input  logic [oal_pkg::ACTION_W-1:0]      action,
  input  logic [oal_pkg::POSITION_W-1:0]    position,
  input  logic [oal_pkg::VALUE_W-1:0]       value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [oal_pkg::STATUS_W-1:0]      status,
  output logic [oal_pkg::VALUE_W-1:0]       read_value,
  output logic [oal_pkg::COUNT_W-1:0]       count
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > oal_pkg::POSITION_W) ? CW : oal_pkg::POSITION_W;
  localparam int XW   = (ENTRY_WIDTH > oal_pkg::VALUE_W) ? ENTRY_WIDTH : oal_pkg::VALUE_W;
  localparam logic [CMPW-1:0] DEPTH_X = CMPW'(DEPTH);

  logic [oal_pkg::CAP_W-1:0]      cap;
  logic [CW-1:0]                  entry_count;
  oal_pkg::act_t                  act;
  logic [oal_pkg::POSITION_W-1:0] pos;
  logic [ENTRY_WIDTH-1:0]         word;
  logic [AW-1:0]                  ptr;
  oal_pkg::res_t                  res;
  logic [oal_pkg::VALUE_W-1:0]    rd_word;

  logic [CMPW-1:0]        count_ext;
  logic [CMPW-1:0]        pos_ext;
  logic [CMPW-1:0]        cap_ext;
  logic [CMPW-1:0]        cap_eff;
  logic [CMPW-1:0]        pos_min;
  logic [AW-1:0]          pos_ins;
  logic [CW-1:0]          count_m1;
  logic [XW-1:0]          value_x;
  logic [XW-1:0]          rdata_x;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [ENTRY_WIDTH-1:0] ram_wdata;
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr;
  logic [ENTRY_WIDTH-1:0] ram_rdata;

  assign count_ext = CMPW'(entry_count);
  assign pos_ext   = CMPW'(pos);
  assign cap_ext   = CMPW'(cap);
  assign cap_eff   = (cap_ext > DEPTH_X) ? DEPTH_X : cap_ext;
  assign pos_min   = (pos_ext < count_ext) ? pos_ext : count_ext;
  assign pos_ins   = pos_min[AW-1:0];
  assign count_m1  = entry_count - 1'b1;
  assign value_x   = XW'(value);
  assign rdata_x   = XW'(ram_rdata);

  assign sts.act          = act;
  assign sts.full         = (count_ext >= cap_eff);
  assign sts.range_err    = (pos_ext >= count_ext);
  assign sts.shift_needed = (count_ext > pos_ext);
  assign sts.more_up      = (CMPW'(ptr) > pos_min);
  assign sts.more_down    = ((CMPW'(ptr) + 1'b1) < count_ext);
  assign sts.out_free     = !out_valid || out_ready;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    if (cmd.up_move) begin
      ram_we    = 1'b1;
      ram_waddr = ptr + 1'b1;
      ram_wdata = ram_rdata;
    end else if (cmd.ins_write) begin
      ram_we    = 1'b1;
      ram_waddr = pos_ins;
      ram_wdata = word;
    end else if (cmd.down_move) begin
      ram_we    = 1'b1;
      ram_waddr = ptr - 1'b1;
      ram_wdata = ram_rdata;
    end
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    if (cmd.rd_start_up) begin
      ram_re    = 1'b1;
      ram_raddr = count_m1[AW-1:0];
    end else if (cmd.rd_start_pos) begin
      ram_re    = 1'b1;
      ram_raddr = pos_ext[AW-1:0];
    end else if (cmd.up_read) begin
      ram_re    = 1'b1;
      ram_raddr = ptr - 1'b1;
    end else if (cmd.next_read) begin
      ram_re    = 1'b1;
      ram_raddr = ptr + 1'b1;
    end
  end

  oal_ram #(
    .WIDTH (ENTRY_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cap         <= oal_pkg::CAP_RESET;
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        cap <= cfg_data;
      end
      if (cmd.clear_count) begin
        entry_count <= '0;
      end else if (cmd.ins_write) begin
        entry_count <= entry_count + 1'b1;
      end else if (cmd.dec_count) begin
        entry_count <= count_m1;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      act     <= oal_pkg::act_t'(action);
      pos     <= position;
      word    <= value_x[ENTRY_WIDTH-1:0];
      res     <= oal_pkg::RES_OK;
      rd_word <= '0;
    end
    if (cmd.set_full) begin
      res <= oal_pkg::RES_FULL;
    end
    if (cmd.set_range) begin
      res <= oal_pkg::RES_RANGE;
    end
    if (cmd.capture) begin
      rd_word <= rdata_x[oal_pkg::VALUE_W-1:0];
    end
    if (cmd.rd_start_up) begin
      ptr <= count_m1[AW-1:0];
    end else if (cmd.rd_start_pos) begin
      ptr <= pos_ext[AW-1:0];
    end else if (cmd.up_read) begin
      ptr <= ptr - 1'b1;
    end else if (cmd.next_read) begin
      ptr <= ptr + 1'b1;
    end
    if (cmd.load_out) begin
      status     <= res;
      read_value <= rd_word;
      count      <= count_ext[oal_pkg::COUNT_W-1:0];
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_ext <= DEPTH_X)
    else $error("Entry count exceeds the store depth.");

  a_port_clash: assert property (@(posedge clk) disable iff (rst)
    ram_we && ram_re |-> ram_waddr != ram_raddr)
    else $error("RAM read and write hit the same address in one cycle.");

  a_out_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !out_valid || out_ready)
    else $error("A result overwrote an item that was not yet taken.");

  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_write |-> count_ext < cap_eff)
    else $error("Insert write issued on a full list.");
`endif

endmodule

[hw/rtl/ordered_array_list_top.sv]
`timescale 1ns / 1ps

// Ordered list of up to DEPTH words with positional insert, get, delete and clear, one item
// at a time with exactly one result item per input item. Entries live in a simple dual-port
// RAM and are shifted one per cycle through its single write port. A taken item is decoded;
// clear and rejected actions go straight to the result, get reads the word at the position,
// insert shifts the entries from the tail down to the position (clamped to the count) up
// one place and writes the word, and a successful delete reads the word there and shifts
// the entries above it down. Each result waits to load until the result register is free
// or being emptied. The result register lets a new item start while the previous result
// waits downstream. The capacity register may be written at any time the block is idle and
// takes effect on the next insert; no clearing pass is needed after reset.
module ordered_array_list_top #(
  parameter int DEPTH       = 64,
  parameter int ENTRY_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [oal_pkg::CAP_W-1:0]      cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [oal_pkg::ACTION_W-1:0]   action,
  input  logic [oal_pkg::POSITION_W-1:0] position,
  input  logic [oal_pkg::VALUE_W-1:0]    value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [oal_pkg::STATUS_W-1:0]   status,
  output logic [oal_pkg::VALUE_W-1:0]    read_value,
  output logic [oal_pkg::COUNT_W-1:0]    count
);

  oal_pkg::cmd_t cmd;
  oal_pkg::sts_t sts;

  oal_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  oal_datapath #(
    .DEPTH       (DEPTH),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .action     (action),
    .position   (position),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .read_value (read_value),
    .count      (count)
  );

endmodule
